/* rtl/kseq_pkg.sv */
// ----------------------------------------------------------------------------
// kseq_pkg
// Shared types, codes and the key-to-text table for the scancode event queue.
// ----------------------------------------------------------------------------
package kseq_pkg;

   localparam int KSEQ_QUEUE_DEPTH = 128;
   localparam int KSEQ_REPEAT_BITS = 8;

   localparam int KEY_COUNT   = 128;
   localparam int KEY_W       = 7;
   localparam int RELEASE_POS = 7;

   // request codes
   localparam logic [1:0] REQ_SCAN  = 2'd0;
   localparam logic [1:0] REQ_POLL  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // event kinds
   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_REPEAT  = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_TEXT    = 2'd3;

   // modifier keys
   localparam logic [KEY_W-1:0] KEY_CTRL   = 7'd29;
   localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'd42;
   localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'd54;
   localparam logic [KEY_W-1:0] KEY_ALT    = 7'd56;

   localparam logic [6:0] CHAR_NONE   = 7'h00;
   localparam logic [6:0] CHAR_SPACE  = 7'h20;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] scan_byte;
      logic [6:0] query_key;
   } kseq_request_type;

   typedef struct packed {
      logic       event_valid;
      logic [1:0] event_kind;
      logic [6:0] event_key;
      logic [7:0] event_repeats;
      logic [6:0] event_char;
      logic       key_down;
      logic [7:0] key_repeats;
      logic [2:0] modifiers;
   } kseq_response_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] key;
      logic [7:0] repeats;
      logic [6:0] char_code;
   } kseq_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [KEY_W-1:0] rd_key;
      logic             wr_en;
      logic [KEY_W-1:0] wr_key;
   } kseq_key_ctl_type;

   typedef struct packed {
      logic read;
      logic pop;
      logic push;
   } kseq_ring_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TEXT
   } kseq_state_type;

   // lower-case character of a set-1 key, none for keys without text
   function automatic logic [6:0] text_of_key(input logic [KEY_W-1:0] key);
      logic [6:0] ch;
      case (key)
         7'd16: ch = 7'h71; // q
         7'd17: ch = 7'h77; // w
         7'd18: ch = 7'h65; // e
         7'd19: ch = 7'h72; // r
         7'd20: ch = 7'h74; // t
         7'd21: ch = 7'h79; // y
         7'd22: ch = 7'h75; // u
         7'd23: ch = 7'h69; // i
         7'd24: ch = 7'h6f; // o
         7'd25: ch = 7'h70; // p
         7'd30: ch = 7'h61; // a
         7'd31: ch = 7'h73; // s
         7'd32: ch = 7'h64; // d
         7'd33: ch = 7'h66; // f
         7'd34: ch = 7'h67; // g
         7'd35: ch = 7'h68; // h
         7'd36: ch = 7'h6a; // j
         7'd37: ch = 7'h6b; // k
         7'd38: ch = 7'h6c; // l
         7'd44: ch = 7'h7a; // z
         7'd45: ch = 7'h78; // x
         7'd46: ch = 7'h63; // c
         7'd47: ch = 7'h76; // v
         7'd48: ch = 7'h62; // b
         7'd49: ch = 7'h6e; // n
         7'd50: ch = 7'h6d; // m
         7'd57: ch = CHAR_SPACE;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/kseq_ram.sv */
// ----------------------------------------------------------------------------
// kseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kseq_key_table.sv */
// ----------------------------------------------------------------------------
// kseq_key_table
// Per-key pressed flag and repeat count in a RAM, with per-key valid bits so
// that reset clears the table at once, and a shadow of the modifier keys.
// ----------------------------------------------------------------------------
module kseq_key_table #(
   parameter int REPEAT_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kseq_pkg::kseq_key_ctl_type ctl,
   input  logic                       wr_down,
   input  logic [REPEAT_BITS-1:0]     wr_repeats,
   output logic                       rd_down,
   output logic [REPEAT_BITS-1:0]     rd_repeats,
   output logic [2:0]                 modifiers
);
   import kseq_pkg::*;

   localparam int ENTRY_W = REPEAT_BITS + 1;

   logic [KEY_COUNT-1:0] valid_ff;
   logic [KEY_COUNT-1:0] valid_in;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic                 ctrl_ff, alt_ff, lshift_ff, rshift_ff;
   logic                 ctrl_in, alt_in, lshift_in, rshift_in;
   logic [ENTRY_W-1:0]   rd_word;

   kseq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEY_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_key),
      .wr_data ({wr_down, wr_repeats}),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_key),
      .rd_data (rd_word)
   );

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      ctrl_in     = ctrl_ff;
      alt_in      = alt_ff;
      lshift_in   = lshift_ff;
      rshift_in   = rshift_ff;
      if (ctl.rd_en) begin
         rd_valid_in = valid_ff[ctl.rd_key];
      end
      if (ctl.wr_en) begin
         valid_in[ctl.wr_key] = 1'b1;
         if (ctl.wr_key == KEY_CTRL)   ctrl_in   = wr_down;
         if (ctl.wr_key == KEY_ALT)    alt_in    = wr_down;
         if (ctl.wr_key == KEY_LSHIFT) lshift_in = wr_down;
         if (ctl.wr_key == KEY_RSHIFT) rshift_in = wr_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         ctrl_ff     <= 1'b0;
         alt_ff      <= 1'b0;
         lshift_ff   <= 1'b0;
         rshift_ff   <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
         ctrl_ff     <= ctrl_in;
         alt_ff      <= alt_in;
         lshift_ff   <= lshift_in;
         rshift_ff   <= rshift_in;
      end
   end

   // an entry never written since reset reads as released with no repeats
   assign rd_down    = rd_valid_ff & rd_word[REPEAT_BITS];
   assign rd_repeats = rd_valid_ff ? rd_word[REPEAT_BITS-1:0] : '0;
   assign modifiers  = {lshift_ff | rshift_ff, alt_ff, ctrl_ff};

endmodule

/* rtl/kseq_event_ring.sv */
// ----------------------------------------------------------------------------
// kseq_event_ring
// Event queue in a RAM with read and write pointers; a push into a full
// queue drops the oldest event.
// ----------------------------------------------------------------------------
module kseq_event_ring #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kseq_pkg::kseq_ring_ctl_type ctl,
   input  kseq_pkg::kseq_entry_type    push_entry,
   output kseq_pkg::kseq_entry_type    head_entry,
   output logic                        empty
);
   import kseq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic [$bits(kseq_entry_type)-1:0] rd_word;

   kseq_ram #(
      .WIDTH ($bits(kseq_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_entry),
      .rd_en   (ctl.read),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_word)
   );

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctl.push) begin
         wr_ptr_in = wr_next;
         // full: the oldest event goes
         if (wr_next == rd_ptr_ff) begin
            rd_ptr_in = rd_next;
         end
      end else if (ctl.pop) begin
         rd_ptr_in = rd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign head_entry = kseq_entry_type'(rd_word);

   a_push_not_empty : assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> !empty)
      else $error("queue empty after a push");

   a_pop_has_event : assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !empty && !ctl.push)
      else $error("pop from empty queue or together with a push");

endmodule

/* rtl/keyboard_scancode_event_queue_top.sv */
// ----------------------------------------------------------------------------
// keyboard_scancode_event_queue_top
// Set-1 scancode decoder: key table and event queue with poll and query.
// Scancode: busy while the key table is written and the key event queued, and
// longer when a text event is also queued (two writes through the single queue
// write port); a new request is taken only when busy drops. Poll and query:
// busy while the memory is read; the result register strobes in the next cycle,
// and a new start can be taken in that cycle as well. The receiver cannot
// stall. Synchronous reset clears pointers, key table valid bits, modifiers.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_queue_top #(
   parameter int QUEUE_DEPTH = kseq_pkg::KSEQ_QUEUE_DEPTH,
   parameter int REPEAT_BITS = kseq_pkg::KSEQ_REPEAT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  kseq_pkg::kseq_request_type  req_payload,
   output logic                        rsp_strobe,
   output kseq_pkg::kseq_response_type rsp_payload
);
   import kseq_pkg::*;

   kseq_state_type    state_ff, state_in;
   kseq_request_type  req_ff, req_in;
   kseq_response_type rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   kseq_key_ctl_type  key_ctl;
   kseq_ring_ctl_type ring_ctl;
   kseq_entry_type    push_entry, head_entry;
   logic              ring_empty;
   logic              accept;

   logic                   old_down, new_down;
   logic [REPEAT_BITS-1:0] old_repeats, new_repeats, inc_repeats;
   logic [2:0]             modifiers;
   logic [KEY_W-1:0]       scan_key;
   logic                   press;
   logic [6:0]             base_char, text_char;
   logic                   need_text;
   logic [REPEAT_BITS+7:0] new_rep_ext, old_rep_ext;
   kseq_entry_type         key_entry, text_entry;

   kseq_key_table #(
      .REPEAT_BITS (REPEAT_BITS)
   ) u_key_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (key_ctl),
      .wr_down    (new_down),
      .wr_repeats (new_repeats),
      .rd_down    (old_down),
      .rd_repeats (old_repeats),
      .modifiers  (modifiers)
   );

   kseq_event_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_event_ring (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ring_ctl),
      .push_entry (push_entry),
      .head_entry (head_entry),
      .empty      (ring_empty)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign req_in = accept ? req_payload : req_ff;

   // key update and event words
   always_comb begin
      scan_key    = req_ff.scan_byte[KEY_W-1:0];
      press       = ~req_ff.scan_byte[RELEASE_POS];
      inc_repeats = old_repeats + 1'b1;
      if (old_down && press) begin
         new_down    = 1'b1;
         new_repeats = (inc_repeats == '0) ? REPEAT_BITS'(1) : inc_repeats;
      end else begin
         new_down    = press;
         new_repeats = '0;
      end
      new_rep_ext = {8'd0, new_repeats};
      old_rep_ext = {8'd0, old_repeats};

      key_entry.key       = scan_key;
      key_entry.repeats   = new_rep_ext[7:0];
      key_entry.char_code = CHAR_NONE;
      if (!press) begin
         key_entry.kind = KIND_RELEASE;
      end else if (new_repeats == '0) begin
         key_entry.kind = KIND_PRESS;
      end else begin
         key_entry.kind = KIND_REPEAT;
      end

      base_char = text_of_key(scan_key);
      need_text = press && (base_char != CHAR_NONE);
      // shift is taken from the table after this byte's update
      if (base_char != CHAR_SPACE && modifiers[2]) begin
         text_char = base_char - CASE_OFFSET;
      end else begin
         text_char = base_char;
      end
      text_entry.kind      = KIND_TEXT;
      text_entry.key       = '0;
      text_entry.repeats   = '0;
      text_entry.char_code = text_char;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (req_ff.req_type == REQ_SCAN && need_text) begin
               state_in = ST_TEXT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TEXT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      key_ctl.rd_en  = accept;
      key_ctl.rd_key = (req_payload.req_type == REQ_QUERY) ?
                       req_payload.query_key : req_payload.scan_byte[KEY_W-1:0];
      key_ctl.wr_en  = 1'b0;
      key_ctl.wr_key = scan_key;
      ring_ctl.read  = accept && (req_payload.req_type == REQ_POLL);
      ring_ctl.pop   = 1'b0;
      ring_ctl.push  = 1'b0;
      push_entry     = key_entry;
      rsp_in         = '0;
      strobe_in      = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (req_ff.req_type)
               REQ_SCAN: begin
                  key_ctl.wr_en = 1'b1;
                  ring_ctl.push = 1'b1;
               end
               REQ_POLL: begin
                  strobe_in = 1'b1;
                  if (!ring_empty) begin
                     ring_ctl.pop         = 1'b1;
                     rsp_in.event_valid   = 1'b1;
                     rsp_in.event_kind    = head_entry.kind;
                     rsp_in.event_key     = head_entry.key;
                     rsp_in.event_repeats = head_entry.repeats;
                     rsp_in.event_char    = head_entry.char_code;
                  end
               end
               REQ_QUERY: begin
                  strobe_in          = 1'b1;
                  rsp_in.key_down    = old_down;
                  rsp_in.key_repeats = old_rep_ext[7:0];
                  rsp_in.modifiers   = modifiers;
               end
               default: begin
               end
            endcase
         end
         ST_TEXT: begin
            ring_ctl.push = 1'b1;
            push_entry    = text_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   a_strobe_after_exec : assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an executed request");

   a_text_after_exec : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEXT |-> $past(state_ff == ST_EXEC) && req_ff.req_type == REQ_SCAN)
      else $error("text push not following a scancode");

   a_text_event_fields : assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.event_valid && rsp_ff.event_kind == KIND_TEXT
      |-> rsp_ff.event_key == '0 && rsp_ff.event_repeats == '0)
      else $error("text event carries a key or repeat count");

endmodule
